// ===== rtl/dws_pkg.sv =====
`default_nettype none

package dws_pkg;

  localparam int HEIGHT_BITS_DEF = 16;

  // pipeline depth, input register to output register
  localparam int NUM_STAGES = 9;

  // stencil coefficients for 1.99 and 0.99, 16 fraction bits
  localparam int COEF_CENTRE = 130417;
  localparam int COEF_PRIOR  = 64881;

  localparam int SCALE_FULL  = 255;

  // rounding of the stencil sum from 28 to 12 fraction bits
  localparam int STEP_SHIFT  = 16;
  localparam int HALF_STEP   = 32768;

  // next height divides by 255 * 2^15, slopes by 255 * 2^9
  localparam int NEXT_SHIFT  = 15;
  localparam int NEXT_BIAS   = SCALE_FULL * (1 << 14);
  localparam int SLOPE_SHIFT = 9;
  localparam int SLOPE_BIAS  = SCALE_FULL * (1 << 8);

  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;

  localparam logic [15:0] WAVE_SCALE_RST    = 16'd16384;
  localparam logic [15:0] DAMPING_SCALE_RST = 16'd32768;
  localparam logic [15:0] INV_SPACING_RST   = 16'd256;

  typedef enum logic [1:0] {
    REG_WAVE_SCALE    = 2'd0,
    REG_DAMPING_SCALE = 2'd1,
    REG_INV_SPACING   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] wave_scale;
    logic [15:0] damping_scale;
    logic [15:0] inv_spacing;
  } cfg_regs_t;

  typedef logic [NUM_STAGES-1:0] stage_en_t;

endpackage

`default_nettype wire

// ===== rtl/dws_if.sv =====
`default_nettype none

interface dws_in_if import dws_pkg::*; #(
  parameter int HB = HEIGHT_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic signed [HB-1:0] centre_height;
  logic signed [HB-1:0] left_height;
  logic signed [HB-1:0] right_height;
  logic signed [HB-1:0] up_height;
  logic signed [HB-1:0] down_height;
  logic signed [HB-1:0] prior_height;
  logic [7:0]           cell_scale;

  modport source (
    output valid, centre_height, left_height, right_height, up_height,
           down_height, prior_height, cell_scale,
    input  ready
  );
  modport sink (
    input  valid, centre_height, left_height, right_height, up_height,
           down_height, prior_height, cell_scale,
    output ready
  );
endinterface

interface dws_out_if import dws_pkg::*; #(
  parameter int HB = HEIGHT_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic signed [HB-1:0] next_height;
  logic signed [HB-1:0] slope_x;
  logic signed [HB-1:0] slope_y;

  modport source (
    output valid, next_height, slope_x, slope_y,
    input  ready
  );
  modport sink (
    input  valid, next_height, slope_x, slope_y,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/dws_ctrl.sv =====
`default_nettype none

module dws_ctrl import dws_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      out_ready,
  output logic           in_ready,
  output logic           out_valid,
  output stage_en_t      en
);

  stage_en_t v_r;
  stage_en_t v_nxt;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    en[NUM_STAGES-1] = !v_r[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (en[0]) begin
      v_nxt[0] = in_valid;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (en[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NUM_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/dws_qsat.sv =====
`default_nettype none

module dws_qsat import dws_pkg::*; #(
  parameter int HB = HEIGHT_BITS_DEF,
  parameter int YW = HEIGHT_BITS_DEF + 16
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic          neg,
  input  wire logic [YW-1:0] y,
  output logic signed [HB-1:0] q_r
);

  localparam int NB = (HB + 8 + 7) / 8;
  localparam int PW = NB * 8;
  localparam logic [HB:0] LIM = (HB+1)'(1) << (HB - 1);
  localparam logic [8:0]  FULL9 = 9'(SCALE_FULL);

  logic                 over;
  logic [PW-1:0]        pad;
  logic [PW-1:0]        quo;
  logic [7:0]           rem;
  logic [8:0]           t;
  logic [HB:0]          q_mag;
  logic signed [HB-1:0] q_nxt;

  // divide by 255 one byte at a time: 256*r + b = 255*r + (r + b)
  always_comb begin
    over = |y[YW-1:HB+8];
    pad  = PW'(y[HB+7:0]);
    quo  = '0;
    rem  = '0;
    t    = '0;
    for (int i = NB - 1; i >= 0; i--) begin
      t = {1'b0, rem} + {1'b0, pad[i*8 +: 8]};
      if (t >= FULL9) begin
        quo[i*8 +: 8] = rem + 8'd1;
        rem           = 8'(t - FULL9);
      end else begin
        quo[i*8 +: 8] = rem;
        rem           = t[7:0];
      end
    end
    q_mag = quo[HB:0];
  end

  always_comb begin
    if (neg) begin
      if (over || q_mag > LIM) begin
        q_nxt = {1'b1, {(HB-1){1'b0}}};
      end else begin
        q_nxt = HB'((HB+1)'(0) - q_mag);
      end
    end else begin
      if (over || q_mag >= LIM) begin
        q_nxt = {1'b0, {(HB-1){1'b1}}};
      end else begin
        q_nxt = HB'(q_mag);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dws_slope.sv =====
`default_nettype none

module dws_slope import dws_pkg::*; #(
  parameter int HB = HEIGHT_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire stage_en_t            en,
  input  wire cfg_regs_t            cfg,
  input  wire logic signed [HB-1:0] a,
  input  wire logic signed [HB-1:0] b,
  input  wire logic [7:0]           s,
  output logic signed [HB-1:0]      q
);

  localparam int YW = HB + 16;

  logic signed [HB:0]   d0_r;
  logic [7:0]           s0_r, s1_r, s2_r;
  logic                 neg1_r, neg2_r, neg3_r, neg4_r;
  logic [HB-1:0]        mag1_r;
  logic [HB+15:0]       m2_r, m2_nxt;
  logic [HB+23:0]       m3_r, m3_nxt;
  logic [YW-1:0]        y4_r, y4_nxt;
  logic signed [HB-1:0] q5;
  logic signed [HB-1:0] q6_r, q7_r, q8_r;

  assign m2_nxt = mag1_r * cfg.inv_spacing;
  assign m3_nxt = m2_r * s2_r;
  assign y4_nxt = YW'(((HB+25)'(m3_r) + (HB+25)'(SLOPE_BIAS)) >> SLOPE_SHIFT);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d0_r <= (HB+1)'(b) - (HB+1)'(a);
      s0_r <= s;
    end
    if (en[1]) begin
      neg1_r <= d0_r[HB];
      mag1_r <= HB'(d0_r[HB] ? -d0_r : d0_r);
      s1_r   <= s0_r;
    end
    if (en[2]) begin
      m2_r   <= m2_nxt;
      neg2_r <= neg1_r;
      s2_r   <= s1_r;
    end
    if (en[3]) begin
      m3_r   <= m3_nxt;
      neg3_r <= neg2_r;
    end
    if (en[4]) begin
      y4_r   <= y4_nxt;
      neg4_r <= neg3_r;
    end
    if (en[6]) begin
      q6_r <= q5;
    end
    if (en[7]) begin
      q7_r <= q6_r;
    end
    if (en[8]) begin
      q8_r <= q7_r;
    end
  end

  dws_qsat #(.HB(HB), .YW(YW)) u_qsat (
    .clk (clk),
    .en  (en[5]),
    .neg (neg4_r),
    .y   (y4_r),
    .q_r (q5)
  );

  assign q = q8_r;

endmodule

`default_nettype wire

// ===== rtl/dws_height.sv =====
`default_nettype none

module dws_height import dws_pkg::*; #(
  parameter int HB = HEIGHT_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire stage_en_t            en,
  input  wire cfg_regs_t            cfg,
  input  wire logic signed [HB-1:0] c,
  input  wire logic signed [HB-1:0] l,
  input  wire logic signed [HB-1:0] r,
  input  wire logic signed [HB-1:0] u,
  input  wire logic signed [HB-1:0] d,
  input  wire logic signed [HB-1:0] p,
  input  wire logic [7:0]           s,
  output logic signed [HB-1:0]      q
);

  localparam int SW = HB + 21;
  localparam int YW = HB + 16;
  localparam logic signed [17:0] CC_S = 18'(COEF_CENTRE);
  localparam logic signed [17:0] CP_S = 18'(COEF_PRIOR);

  logic signed [HB+2:0]  lap0_r;
  logic signed [HB-1:0]  c0_r, p0_r;
  logic [7:0]            s0_r, s1_r, s2_r, s3_r, s4_r, s5_r;
  logic signed [HB+19:0] m1w_r, m1w_nxt;
  logic signed [HB+17:0] m1c_r, m1c_nxt;
  logic signed [HB+17:0] m1p_r, m1p_nxt;
  logic signed [SW-1:0]  sum2_r, sum2_nxt;
  logic                  neg3_r, neg4_r, neg5_r, neg6_r, neg7_r;
  logic [SW-1:0]         mag3_r;
  logic [HB+5:0]         mag4_r, mag4_nxt;
  logic [HB+21:0]        p5_r, p5_nxt;
  logic [HB+29:0]        p6_r, p6_nxt;
  logic [YW-1:0]         y7_r, y7_nxt;

  assign m1w_nxt  = lap0_r * $signed({1'b0, cfg.wave_scale});
  assign m1c_nxt  = c0_r * CC_S;
  assign m1p_nxt  = p0_r * CP_S;
  assign sum2_nxt = SW'(m1w_r) + SW'(m1c_r) - SW'(m1p_r);
  // round half away from zero on the magnitude
  assign mag4_nxt = (HB+6)'(((SW+1)'(mag3_r) + (SW+1)'(HALF_STEP)) >> STEP_SHIFT);
  assign p5_nxt   = mag4_r * cfg.damping_scale;
  assign p6_nxt   = p5_r * s5_r;
  assign y7_nxt   = YW'(((HB+31)'(p6_r) + (HB+31)'(NEXT_BIAS)) >> NEXT_SHIFT);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      lap0_r <= (HB+3)'(l) + (HB+3)'(r) + (HB+3)'(u) + (HB+3)'(d)
              - ((HB+3)'(c) <<< 2);
      c0_r   <= c;
      p0_r   <= p;
      s0_r   <= s;
    end
    if (en[1]) begin
      m1w_r <= m1w_nxt;
      m1c_r <= m1c_nxt;
      m1p_r <= m1p_nxt;
      s1_r  <= s0_r;
    end
    if (en[2]) begin
      sum2_r <= sum2_nxt;
      s2_r   <= s1_r;
    end
    if (en[3]) begin
      neg3_r <= sum2_r[SW-1];
      mag3_r <= sum2_r[SW-1] ? SW'(-sum2_r) : SW'(sum2_r);
      s3_r   <= s2_r;
    end
    if (en[4]) begin
      mag4_r <= mag4_nxt;
      neg4_r <= neg3_r;
      s4_r   <= s3_r;
    end
    if (en[5]) begin
      p5_r   <= p5_nxt;
      neg5_r <= neg4_r;
      s5_r   <= s4_r;
    end
    if (en[6]) begin
      p6_r   <= p6_nxt;
      neg6_r <= neg5_r;
    end
    if (en[7]) begin
      y7_r   <= y7_nxt;
      neg7_r <= neg6_r;
    end
  end

  dws_qsat #(.HB(HB), .YW(YW)) u_qsat (
    .clk (clk),
    .en  (en[8]),
    .neg (neg7_r),
    .y   (y7_r),
    .q_r (q)
  );

endmodule

`default_nettype wire

// ===== rtl/damped_wave_stencil_cell_top.sv =====
// throughput: one beat per cycle; the nine-stage pipeline moves on whenever its
//   last stage is empty or the result beat is taken, and bubbles are squeezed out
// reset: synchronous, active low; clears all stage valid bits and loads
//   wave_scale 16384, damping_scale 32768 and inv_spacing 256
`default_nettype none

module damped_wave_stencil_cell_top import dws_pkg::*; #(
  parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  dws_in_if.sink                     in_bus,
  dws_out_if.source                  out_bus,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready
);

  cfg_regs_t cfg_r;
  cfg_regs_t cfg_nxt;
  logic      cfg_wr;
  reg_idx_t  reg_idx;
  stage_en_t en;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_WAVE_SCALE:    cfg_nxt.wave_scale    = pwdata[15:0];
        REG_DAMPING_SCALE: cfg_nxt.damping_scale = pwdata[15:0];
        REG_INV_SPACING:   cfg_nxt.inv_spacing   = pwdata[15:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WAVE_SCALE:    prdata = CFG_DATA_W'(cfg_r.wave_scale);
      REG_DAMPING_SCALE: prdata = CFG_DATA_W'(cfg_r.damping_scale);
      REG_INV_SPACING:   prdata = CFG_DATA_W'(cfg_r.inv_spacing);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wave_scale    <= WAVE_SCALE_RST;
      cfg_r.damping_scale <= DAMPING_SCALE_RST;
      cfg_r.inv_spacing   <= INV_SPACING_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .out_ready (out_bus.ready),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .en        (en)
  );

  dws_height #(.HB(HEIGHT_BITS)) u_height (
    .clk (clk),
    .en  (en),
    .cfg (cfg_r),
    .c   (in_bus.centre_height),
    .l   (in_bus.left_height),
    .r   (in_bus.right_height),
    .u   (in_bus.up_height),
    .d   (in_bus.down_height),
    .p   (in_bus.prior_height),
    .s   (in_bus.cell_scale),
    .q   (out_bus.next_height)
  );

  // horizontal gradient from right minus left
  dws_slope #(.HB(HEIGHT_BITS)) u_slope_x (
    .clk (clk),
    .en  (en),
    .cfg (cfg_r),
    .a   (in_bus.left_height),
    .b   (in_bus.right_height),
    .s   (in_bus.cell_scale),
    .q   (out_bus.slope_x)
  );

  // vertical gradient from down minus up
  dws_slope #(.HB(HEIGHT_BITS)) u_slope_y (
    .clk (clk),
    .en  (en),
    .cfg (cfg_r),
    .a   (in_bus.up_height),
    .b   (in_bus.down_height),
    .s   (in_bus.cell_scale),
    .q   (out_bus.slope_y)
  );

  // input side blocks only when every stage is full and the result is held
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> (out_bus.valid && !out_bus.ready))
    else $error("input stalled while pipeline can advance");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_bus.valid)
    else $error("result beat valid right after reset");

  a_cfg_wave: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && paddr[3:2] == REG_WAVE_SCALE) |=>
      cfg_r.wave_scale == $past(pwdata[15:0]))
    else $error("wave_scale write lost");

  a_cfg_damp: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && paddr[3:2] == REG_DAMPING_SCALE) |=>
      cfg_r.damping_scale == $past(pwdata[15:0]))
    else $error("damping_scale write lost");

endmodule

`default_nettype wire
